// File: rtl/pkbrle_pkg.sv
package pkbrle_pkg;

	localparam int UNIT_CFG_W  = 3;
	localparam int CFG_ADDR_W  = 2;
	localparam int PACK_UNITS  = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_UNIT_BYTES   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_BYTES = 2'd1;

	localparam logic [7:0] PAD_HEADER = 8'h80;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_TRUNC    = 2'd2,
		STAT_SHORT    = 2'd3
	} status_t;

	// One decoded unit repeated count times; count zero only on a bare frame end.
	typedef struct packed {
		logic [31:0] unit;
		logic [7:0]  count;
		logic        done;
		status_t     status;
	} cmd_t;

endpackage

// File: rtl/pkbrle_if.sv
interface pkbrle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface pkbrle_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] unit_first;
	logic [31:0] unit_second;
	logic [1:0]  units_valid;
	logic        frame_done;
	logic [1:0]  status;
	logic        last_of_run;

	modport source(output valid, unit_first, unit_second, units_valid, frame_done, status,
		last_of_run, input ready);
	modport sink(input valid, unit_first, unit_second, units_valid, frame_done, status,
		last_of_run, output ready);
endinterface

interface pkbrle_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [31:0] data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// File: rtl/pkbrle_front.sv
module pkbrle_front import pkbrle_pkg::*; #(
	parameter int MAX_UNIT_BYTES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pkbrle_byte_if.sink           stream,
	input  logic [UNIT_CFG_W-1:0] unit_bytes,
	input  logic [31:0]           output_bytes,
	output logic                  push,
	output cmd_t                  cmd,
	input  logic                  full
);

	localparam int ACC_W  = 8 * MAX_UNIT_BYTES;
	localparam int LANE_W = (MAX_UNIT_BYTES > 1) ? $clog2(MAX_UNIT_BYTES) : 1;
	localparam int UNIT_W = $clog2(MAX_UNIT_BYTES + 1);
	localparam int PROD_W = 8 + UNIT_W;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LITERAL,
		PH_REPLICATE,
		PH_OVERFLOW
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [7:0]          units_left_q, units_left_n;
	logic [LANE_W-1:0]   lane_q, lane_n;
	logic [ACC_W-1:0]    acc_q, acc_n, acc_g;
	logic [31:0]         bw_q, bw_n;

	logic                accept;
	logic [UNIT_W-1:0]   unit;
	logic [7:0]          runlen;
	logic [32:0]         need;
	logic                complete;
	logic                emit;
	logic                trunc;
	logic [7:0]          cnt;
	logic [31:0]         cmd_unit;
	status_t             stat;

	assign stream.ready = !full;
	assign accept = stream.valid && stream.ready;

	always_comb begin
		if (unit_bytes == '0) begin
			unit = UNIT_W'(1);
		end else if (int'(unit_bytes) > MAX_UNIT_BYTES) begin
			unit = UNIT_W'(MAX_UNIT_BYTES);
		end else begin
			unit = UNIT_W'(unit_bytes);
		end
	end

	// 0..127 -> n+1 units, 129..255 -> 257-n units
	assign runlen = stream.data_byte[7] ? (~stream.data_byte + 8'd2) : (stream.data_byte + 8'd1);
	assign need = 33'(bw_q) + 33'(PROD_W'(runlen) * PROD_W'(unit));

	assign acc_g = acc_q | (ACC_W'(stream.data_byte) << {lane_q, 3'b000});
	assign complete = (UNIT_W'(lane_q) + UNIT_W'(1)) >= unit;

	always_comb begin
		phase_n      = phase_q;
		units_left_n = units_left_q;
		lane_n       = lane_q;
		acc_n        = acc_q;
		bw_n         = bw_q;
		emit         = 1'b0;
		trunc        = 1'b0;
		cnt          = '0;
		cmd_unit     = '0;
		unique case (phase_q)
			PH_HEADER: begin
				if (bw_q < output_bytes && stream.data_byte != PAD_HEADER) begin
					if (stream.last_byte) begin
						trunc = 1'b1;
					end else if (need > {1'b0, output_bytes}) begin
						phase_n = PH_OVERFLOW;
					end else begin
						phase_n      = stream.data_byte[7] ? PH_REPLICATE : PH_LITERAL;
						units_left_n = runlen;
						lane_n       = '0;
						acc_n        = '0;
					end
				end
			end
			PH_LITERAL: begin
				if (complete) begin
					emit         = 1'b1;
					cnt          = 8'd1;
					cmd_unit     = 32'(acc_g);
					bw_n         = bw_q + 32'(unit);
					acc_n        = '0;
					lane_n       = '0;
					units_left_n = units_left_q - 8'd1;
					if (units_left_q == 8'd1) begin
						phase_n = PH_HEADER;
					end
				end else begin
					acc_n  = acc_g;
					lane_n = lane_q + LANE_W'(1);
				end
			end
			PH_REPLICATE: begin
				if (complete) begin
					emit         = 1'b1;
					cnt          = units_left_q;
					cmd_unit     = 32'(acc_g);
					bw_n         = bw_q + 32'(PROD_W'(units_left_q) * PROD_W'(unit));
					units_left_n = '0;
					acc_n        = '0;
					lane_n       = '0;
					phase_n      = PH_HEADER;
				end else begin
					acc_n  = acc_g;
					lane_n = lane_q + LANE_W'(1);
				end
			end
			PH_OVERFLOW: begin
				// swallow until frame end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		priority if (trunc) begin
			stat = STAT_TRUNC;
		end else if (phase_n == PH_OVERFLOW) begin
			stat = STAT_OVERFLOW;
		end else if (phase_n == PH_LITERAL || phase_n == PH_REPLICATE) begin
			stat = STAT_TRUNC;
		end else if (bw_n == output_bytes) begin
			stat = STAT_OK;
		end else begin
			stat = STAT_SHORT;
		end
	end

	assign push       = accept && (emit || stream.last_byte);
	assign cmd.unit   = cmd_unit;
	assign cmd.count  = cnt;
	assign cmd.done   = stream.last_byte;
	assign cmd.status = stream.last_byte ? stat : STAT_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			units_left_q <= '0;
			lane_q       <= '0;
			acc_q        <= '0;
			bw_q         <= '0;
		end else if (accept) begin
			if (stream.last_byte) begin
				phase_q      <= PH_HEADER;
				units_left_q <= '0;
				lane_q       <= '0;
				acc_q        <= '0;
				bw_q         <= '0;
			end else begin
				phase_q      <= phase_n;
				units_left_q <= units_left_n;
				lane_q       <= lane_n;
				acc_q        <= acc_n;
				bw_q         <= bw_n;
			end
		end
	end

endmodule

// File: rtl/pkbrle_queue.sv
module pkbrle_queue import pkbrle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic full,
	output logic empty
);

	cmd_t                   mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full   = count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
	assign empty  = count_q == '0;
	assign rd_cmd = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_PTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_PTR_W + 1)'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");

endmodule

// File: rtl/pkbrle_back.sv
module pkbrle_back import pkbrle_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  cmd_t           q_cmd,
	input  logic           q_empty,
	output logic           q_pop,
	pkbrle_result_if.source result
);

	logic        act_q;
	logic [31:0] unit_q;
	logic [7:0]  rem_q;
	logic        done_q;
	status_t     status_q;

	logic        final_res;
	logic        take;

	assign final_res = rem_q <= 8'(PACK_UNITS);
	assign take      = result.valid && result.ready;
	assign q_pop     = !q_empty && (!act_q || (take && final_res));

	assign result.valid       = act_q;
	assign result.unit_first  = unit_q;
	assign result.unit_second = (rem_q >= 8'(PACK_UNITS)) ? unit_q : '0;
	assign result.units_valid = final_res ? 2'(rem_q) : 2'(PACK_UNITS);
	assign result.last_of_run = final_res;
	assign result.frame_done  = final_res && done_q;
	assign result.status      = (final_res && done_q) ? status_q : STAT_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (q_pop) begin
			act_q <= 1'b1;
		end else if (take && final_res) begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			unit_q   <= q_cmd.unit;
			rem_q    <= q_cmd.count;
			done_q   <= q_cmd.done;
			status_q <= q_cmd.status;
		end else if (take && !final_res) begin
			rem_q <= rem_q - 8'(PACK_UNITS);
		end
	end

	a_empty_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q && rem_q == '0) |-> done_q)
		else $error("result with no units outside frame end");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !final_res) |=> (act_q && rem_q == $past(rem_q) - 8'(PACK_UNITS)))
		else $error("replicate count did not advance");
	a_done_closes_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q && result.frame_done) |-> result.last_of_run)
		else $error("frame end not on last result of its byte");

endmodule

// File: rtl/packbits_unit_rle_decoder_core.sv
// PackBits decoder for runs of 1 to 4 byte units.
// stream: one compressed byte per transfer, last_byte closes the frame.
// result: up to two decoded units per transfer; last_of_run marks the final
//   result caused by one input byte, frame_done and status close the frame.
// cfg: register writes (index 0 unit_bytes, 1 output_bytes), always ready;
//   write only while no frame is in flight.
// Timing: a byte is taken every cycle while the two-entry command queue has
//   room. With the queue and the output idle, a byte's command is written to
//   the queue and then loaded into the output register, making its result
//   valid. A literal unit is one result; a replicate run of n units needs
//   ceil(n/2) results (up to 64), during which the front keeps taking bytes
//   until the queue fills, then holds stream.ready low.
// The output expander sets the sustained rate: one result per cycle when not stalled.
// A stalled result holds until taken; nothing is dropped.
// Reset: run state, byte count and queue clear; unit_bytes goes to 1 and
//   output_bytes to 0. Every frame end also clears the run state.
module packbits_unit_rle_decoder_core import pkbrle_pkg::*; #(
	parameter int MAX_UNIT_BYTES = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	pkbrle_byte_if.sink     stream,
	pkbrle_result_if.source result,
	pkbrle_cfg_if.sink      cfg
);

	logic [UNIT_CFG_W-1:0] unit_bytes_q;
	logic [31:0]           output_bytes_q;

	logic push, pop, full, empty;
	cmd_t wr_cmd, rd_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_bytes_q   <= UNIT_CFG_W'(1);
			output_bytes_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.addr)
				REG_UNIT_BYTES:   unit_bytes_q   <= cfg.data[UNIT_CFG_W-1:0];
				REG_OUTPUT_BYTES: output_bytes_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	pkbrle_front #(
		.MAX_UNIT_BYTES(MAX_UNIT_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream       (stream),
		.unit_bytes   (unit_bytes_q),
		.output_bytes (output_bytes_q),
		.push         (push),
		.cmd          (wr_cmd),
		.full         (full)
	);

	pkbrle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.full   (full),
		.empty  (empty)
	);

	pkbrle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (rd_cmd),
		.q_empty (empty),
		.q_pop   (pop),
		.result  (result)
	);

endmodule
